// ----- hdl/gbre_pkg.sv -----
// shared types and constants for the grid bin range enumerator
`default_nettype none

package gbre_pkg;

    // width of a bound numerator: coordinate differences plus a 31-bit extent
    localparam int NUM_W = 35;
    // width of a clamped bin coordinate
    localparam int BND_W = 3;
    // width of a bin count
    localparam int CNT_W = 4;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_ORIGIN = 3'd0,
        CFG_Y_ORIGIN = 3'd1,
        CFG_BIN_SIDE = 3'd2,
        CFG_ACROSS   = 3'd3,
        CFG_DOWN     = 3'd4
    } cfg_index_t;

    // one query rectangle
    typedef struct packed {
        logic signed [31:0] rect_x;
        logic signed [31:0] rect_y;
        logic        [30:0] rect_width;
        logic        [30:0] rect_height;
    } rect_item_t;

    // one touched bin
    typedef struct packed {
        logic [5:0] bin_index;
        logic [2:0] bin_col;
        logic [2:0] bin_row;
        logic       last;
    } bin_result_t;

    // grid settings as seen by the front end, counts already clamped
    typedef struct packed {
        logic signed [31:0] x_origin;
        logic signed [31:0] y_origin;
        logic        [30:0] bin_side;
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
    } grid_cfg_t;

    // bin span of one query, handed from front to back
    typedef struct packed {
        logic [BND_W-1:0] col_lo;
        logic [BND_W-1:0] col_hi;
        logic [BND_W-1:0] row_lo;
        logic [BND_W-1:0] row_hi;
        logic [CNT_W-1:0] cols;
    } bin_span_t;

endpackage

`default_nettype wire

// ----- hdl/grid_bin_range_enumerator.sv -----
// top level: configuration registers, bound front end, span queue, bin walker
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | in_data   (rect_item_t)
//  out      | out_valid / out_stall   | out_data  (bin_result_t)
//  cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  the front end handles one query at a time: accept, then for each of the four
//  bounds one load and four steps of the shared compare-subtract unit, then a push
//  the back end emits one bin per cycle while out_stall is low, and loads each span
//  in an idle state before its walk, so front and back work on queries side by side
//  reset clears all control state; config returns to origin 0, side 1, 8 x 8 bins
//  in_stall is high whenever the front end is busy; out_stall holds the output
//  register and the walk while the span queue lets the front end keep going
`default_nettype none

module grid_bin_range_enumerator #(
    parameter int MAX_BINS_X = 8,
    parameter int MAX_BINS_Y = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  gbre_pkg::rect_item_t  in_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output gbre_pkg::bin_result_t out_data,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire [2:0]             cfg_index,
    input  wire [31:0]            cfg_data
);
    import gbre_pkg::*;

    logic signed [31:0] x_origin_reg;
    logic signed [31:0] y_origin_reg;
    logic [30:0]        side_reg;
    logic [CNT_W-1:0]   across_reg;
    logic [CNT_W-1:0]   down_reg;

    grid_cfg_t          cfg;
    logic               push_valid;
    bin_span_t          push_data;
    logic               full;
    logic               pop;
    bin_span_t          pop_data;
    logic               empty;
    logic               cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            side_reg     <= 31'd1;
            across_reg   <= CNT_W'(8);
            down_reg     <= CNT_W'(8);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_X_ORIGIN: x_origin_reg <= cfg_data;
                CFG_Y_ORIGIN: y_origin_reg <= cfg_data;
                CFG_BIN_SIDE: side_reg     <= cfg_data[30:0];
                CFG_ACROSS:   across_reg   <= cfg_data[CNT_W-1:0];
                CFG_DOWN:     down_reg     <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // effective grid: zero side reads as one, counts clamped to 1..max
    always_comb
    begin
        cfg.x_origin = x_origin_reg;
        cfg.y_origin = y_origin_reg;
        cfg.bin_side = (side_reg == '0) ? 31'd1 : side_reg;
        if (across_reg == '0)
            cfg.cols = CNT_W'(1);
        else if (across_reg > CNT_W'(MAX_BINS_X))
            cfg.cols = CNT_W'(MAX_BINS_X);
        else
            cfg.cols = across_reg;
        if (down_reg == '0)
            cfg.rows = CNT_W'(1);
        else if (down_reg > CNT_W'(MAX_BINS_Y))
            cfg.rows = CNT_W'(MAX_BINS_Y);
        else
            cfg.rows = down_reg;
    end

    gbre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (full)
    );

    gbre_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .pop_data   (pop_data),
        .empty      (empty)
    );

    gbre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- hdl/gbre_front.sv -----
// front end: accepts a query and works out its clamped column and row bounds
`default_nettype none

module gbre_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  gbre_pkg::rect_item_t   in_data,
    input  gbre_pkg::grid_cfg_t    cfg,
    output logic                   push_valid,
    output gbre_pkg::bin_span_t    push_data,
    input  wire                    full
);
    import gbre_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_LOAD = 4'b0010,
        F_STEP = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t            state_reg, state_next;
    logic [1:0]              bnd_reg, bnd_next;
    logic [1:0]              step_reg, step_next;
    logic [NUM_W-1:0]        rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic                    sat_reg, sat_next;
    logic [BND_W-1:0]        q_reg, q_next;
    logic signed [NUM_W-1:0] num_reg [4];
    logic signed [NUM_W-1:0] num_next [4];
    logic [BND_W-1:0]        bound_reg [4];
    logic [BND_W-1:0]        bound_next;
    logic                    bound_wr;

    logic                    accept;
    logic signed [NUM_W-1:0] x_ext, y_ext, xo_ext, yo_ext, w_ext, h_ext;
    logic [1:0]              shift_amt;
    logic [NUM_W-1:0]        divisor;
    logic                    ge;
    logic [BND_W-1:0]        lim;
    logic [BND_W-1:0]        q_final;

    assign accept   = in_valid && (state_reg == F_IDLE);
    assign in_stall = (state_reg != F_IDLE);

    // bound numerators, wide enough that nothing wraps
    always_comb
    begin
        x_ext  = {{(NUM_W-32){in_data.rect_x[31]}}, in_data.rect_x};
        y_ext  = {{(NUM_W-32){in_data.rect_y[31]}}, in_data.rect_y};
        xo_ext = {{(NUM_W-32){cfg.x_origin[31]}}, cfg.x_origin};
        yo_ext = {{(NUM_W-32){cfg.y_origin[31]}}, cfg.y_origin};
        w_ext  = {{(NUM_W-31){1'b0}}, in_data.rect_width};
        h_ext  = {{(NUM_W-31){1'b0}}, in_data.rect_height};
        num_next[0] = x_ext - NUM_W'(1) - xo_ext;
        num_next[1] = x_ext + w_ext - xo_ext;
        num_next[2] = y_ext - NUM_W'(1) - yo_ext;
        num_next[3] = y_ext + h_ext - yo_ext;
    end

    // restoring divide step: first step checks for eight or more bins,
    // then one quotient bit per step
    always_comb
    begin
        shift_amt = 2'd3 - step_reg;
        divisor   = {{(NUM_W-31){1'b0}}, cfg.bin_side} << shift_amt;
        ge        = (rem_reg >= divisor);
        lim       = bnd_reg[1] ? BND_W'(cfg.rows - CNT_W'(1)) : BND_W'(cfg.cols - CNT_W'(1));
        q_final   = {q_reg[BND_W-2:0], ge};
        if (neg_reg)
            bound_next = '0;
        else if (sat_reg || (q_final > lim))
            bound_next = lim;
        else
            bound_next = q_final;
    end

    // sequencer over the four bounds
    always_comb
    begin
        state_next = state_reg;
        bnd_next   = bnd_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        sat_next   = sat_reg;
        q_next     = q_reg;
        bound_wr   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    bnd_next   = 2'd0;
                    state_next = F_LOAD;
                end
            end
            F_LOAD:
            begin
                rem_next   = num_reg[bnd_reg];
                neg_next   = num_reg[bnd_reg][NUM_W-1];
                sat_next   = 1'b0;
                q_next     = '0;
                step_next  = 2'd0;
                state_next = F_STEP;
            end
            F_STEP:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd0)
                    sat_next = ge;
                else
                begin
                    q_next = q_final;
                    if (ge)
                        rem_next = rem_reg - divisor;
                end
                if (step_reg == 2'd3)
                begin
                    bound_wr = 1'b1;
                    if (bnd_reg == 2'd3)
                        state_next = F_PUSH;
                    else
                    begin
                        bnd_next   = bnd_reg + 2'd1;
                        state_next = F_LOAD;
                    end
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push_valid = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // span handed to the queue
    always_comb
    begin
        push_data.col_lo = bound_reg[0];
        push_data.col_hi = bound_reg[1];
        push_data.row_lo = bound_reg[2];
        push_data.row_hi = bound_reg[3];
        push_data.cols   = cfg.cols;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            bnd_reg   <= 2'd0;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            bnd_reg   <= bnd_next;
            step_reg  <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        q_reg   <= q_next;
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
                num_reg[i] <= num_next[i];
        end
        if (bound_wr)
            bound_reg[bnd_reg] <= bound_next;
    end

    // a taken query starts the first bound next cycle
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == F_LOAD))
        else $error("front did not start bound search after accept");

    // low bound never above high bound
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> ((push_data.col_lo <= push_data.col_hi) &&
                        (push_data.row_lo <= push_data.row_hi)))
        else $error("bin span out of order");

    // bounds stay inside the grid
    a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (({1'b0, push_data.col_hi} < cfg.cols) &&
                        ({1'b0, push_data.row_hi} < cfg.rows)))
        else $error("bin span beyond grid");

endmodule

`default_nettype wire

// ----- hdl/gbre_fifo.sv -----
// short queue of bin spans between front and back
`default_nettype none

module gbre_fifo #(
    parameter int DEPTH = 2
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push_valid,
    input  gbre_pkg::bin_span_t  push_data,
    output logic                 full,
    input  wire                  pop,
    output gbre_pkg::bin_span_t  pop_data,
    output logic                 empty
);
    import gbre_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_Q = $clog2(DEPTH + 1);

    bin_span_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_Q'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_Q'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_Q'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // the front only pushes into free space
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !full)
        else $error("span pushed into full queue");

    // fill level tracks pointer distance
    a_fill_level: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CNT_Q'(DEPTH) && count_reg != '0) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

// ----- hdl/gbre_back.sv -----
// back end: walks the bins of one span and emits one beat per bin
`default_nettype none

module gbre_back (
    input  wire                   clk,
    input  wire                   rst_n,
    output logic                  pop,
    input  gbre_pkg::bin_span_t   pop_data,
    input  wire                   empty,
    output logic                  out_valid,
    input  wire                   out_stall,
    output gbre_pkg::bin_result_t out_data
);
    import gbre_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    bin_span_t         span_reg, span_next;
    logic [BND_W-1:0]  col_reg, col_next;
    logic [BND_W-1:0]  row_reg, row_next;
    logic              out_valid_reg, out_valid_next;
    bin_result_t       out_data_reg, out_data_next;

    logic              slot_free;
    logic              at_last;
    logic [6:0]        index_wide;

    assign slot_free = !out_valid_reg || !out_stall;
    assign at_last   = (col_reg == span_reg.col_hi) && (row_reg == span_reg.row_hi);
    assign index_wide = 7'(row_reg) * 7'(span_reg.cols) + 7'(col_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // row-major walk with a one-beat output register
    always_comb
    begin
        state_next     = state_reg;
        span_next      = span_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        if (slot_free)
            out_valid_next = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    span_next  = pop_data;
                    col_next   = pop_data.col_lo;
                    row_next   = pop_data.row_lo;
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (slot_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.bin_index = index_wide[5:0];
                    out_data_next.bin_col   = col_reg;
                    out_data_next.bin_row   = row_reg;
                    out_data_next.last      = at_last;
                    if (at_last)
                        state_next = B_IDLE;
                    else if (col_reg == span_reg.col_hi)
                    begin
                        col_next = span_reg.col_lo;
                        row_next = row_reg + BND_W'(1);
                    end
                    else
                        col_next = col_reg + BND_W'(1);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk position and result payload
    always_ff @(posedge clk)
    begin
        span_reg     <= span_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        out_data_reg <= out_data_next;
    end

    // a result that is not the last leaves the walk running
    a_run_after_middle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.last) |-> (state_reg == B_RUN))
        else $error("walk ended before last bin");

    // walk position stays inside the span
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RUN) |-> ((col_reg >= span_reg.col_lo) &&
                                  (col_reg <= span_reg.col_hi) &&
                                  (row_reg >= span_reg.row_lo) &&
                                  (row_reg <= span_reg.row_hi)))
        else $error("walk position outside span");

endmodule

`default_nettype wire
